// ----- rtl/core/tass_pkg.sv -----
package tass_pkg;

  // Sizing of the block
  localparam int MAX_DIM   = 1024;
  localparam int ADDR_BITS = 24;

  // Fixed field widths
  localparam int ELEM_W    = 64;
  localparam int DIM_W     = 11;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = DIM_W;

  // Coordinate counters hold values below MAX_DIM
  localparam int COORD_W = $clog2(MAX_DIM);

  // Product widths along the address pipeline
  localparam int PAIR_W = 2 * DIM_W;            // product of two sizes
  localparam int M1_W   = DIM_W + COORD_W;      // size times coordinate
  localparam int M2_W   = PAIR_W + COORD_W;     // size pair times coordinate
  localparam int MD_W   = PAIR_W + M1_W;        // volume times outer coordinate
  localparam int SUM_W  = MD_W + 2;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ELEM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_BITS + ELEM_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_FOUR  = 3'd4;

  // Swap modes; code three behaves as MODE_SWAP23
  localparam logic [MODE_W-1:0] MODE_SWAP12 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP13 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP23 = 2'd2;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Size zero counts as one, sizes above MAX_DIM are clamped
  function automatic dim_t eff_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Coordinate sits at (or beyond) the end of its axis
  function automatic logic at_end(input coord_t c, input dim_t n);
    return (32'(c) + 32'd1) >= 32'(n);
  endfunction

endpackage

// ----- rtl/core/tensor_axis_swap_scatter_unit.sv -----
// Axis-swap scatter address generator.
// Each accepted input passes the stage-1, stage-2 and output registers to the master side.
// Throughput: one element per cycle unless stalled; a 3-stage mul/add pipe forms stride products.
// Backpressure stalls only the full stages, bubbles are squeezed out.
// Reset (rst, synchronous): pipe empty, coordinates zero, mode 0, all sizes 1.
module tensor_axis_swap_scatter_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tass_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tass_pkg::CFG_W-1:0]         cfg_data,
  // element input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tass_pkg::IN_DATA_W-1:0]     s_tdata,   // [63:0] element
  input  logic                               s_tuser,   // [0] first
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tass_pkg::OUT_DATA_W-1:0]    m_tdata,   // [23:0] dest_address, [87:24] element_out
  output logic                               m_tlast,   // last element of the tensor
  output logic                               m_tuser    // [0] range_error
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must come only while the pipe is idle, so the stages
  // below read them freely; the block itself does not enforce this (cfg_ready stays high).
  // ---------------------------------------------------------------------------
  logic [tass_pkg::MODE_W-1:0] mode;
  tass_pkg::dim_t dim_one, dim_two, dim_three, dim_four;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= tass_pkg::MODE_SWAP12;
      dim_one   <= tass_pkg::DIM_W'(1);
      dim_two   <= tass_pkg::DIM_W'(1);
      dim_three <= tass_pkg::DIM_W'(1);
      dim_four  <= tass_pkg::DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        tass_pkg::REG_MODE:      mode      <= cfg_data[tass_pkg::MODE_W-1:0];
        tass_pkg::REG_DIM_ONE:   dim_one   <= cfg_data;
        tass_pkg::REG_DIM_TWO:   dim_two   <= cfg_data;
        tass_pkg::REG_DIM_THREE: dim_three <= cfg_data;
        tass_pkg::REG_DIM_FOUR:  dim_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage moves when it is empty or its successor moves.
  // ---------------------------------------------------------------------------
  logic v1, v2;
  logic out_ready, s2_ready, accept;

  assign out_ready = !m_tvalid || m_tready;
  assign s2_ready  = !v2 || out_ready;
  assign s_tready  = !v1 || s2_ready;
  assign accept    = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Stage 0: source coordinate counter and first products.
  // ---------------------------------------------------------------------------
  tass_pkg::coord_t coord_a, coord_b, coord_c, coord_d;
  tass_pkg::coord_t coord_a_next, coord_b_next, coord_c_next, coord_d_next;
  tass_pkg::coord_t cur_a, cur_b, cur_c, cur_d;
  tass_pkg::dim_t   n1, n2, n3, n4;
  logic             three_d;
  logic             end_a, end_b, end_c, end_d;
  logic             fin;

  assign n1 = tass_pkg::eff_dim(dim_one);
  assign n2 = tass_pkg::eff_dim(dim_two);
  assign n3 = tass_pkg::eff_dim(dim_three);
  assign n4 = tass_pkg::eff_dim(dim_four);

  assign three_d = (mode == tass_pkg::MODE_SWAP12);

  // first flag restarts at the origin; outer axis unused in 3-D mode
  assign cur_a = s_tuser ? '0 : coord_a;
  assign cur_b = s_tuser ? '0 : coord_b;
  assign cur_c = s_tuser ? '0 : coord_c;
  assign cur_d = (s_tuser || three_d) ? '0 : coord_d;

  assign end_a = tass_pkg::at_end(cur_a, n1);
  assign end_b = tass_pkg::at_end(cur_b, n2);
  assign end_c = tass_pkg::at_end(cur_c, n3);
  assign end_d = tass_pkg::at_end(cur_d, n4);

  assign fin = end_a && end_b && end_c && (three_d || end_d);

  // mixed-radix advance; a coordinate past its size wraps like one at its end
  always_comb begin
    coord_a_next = end_a ? '0 : cur_a + tass_pkg::COORD_W'(1);
    coord_b_next = cur_b;
    coord_c_next = cur_c;
    coord_d_next = cur_d;
    if (end_a) begin
      coord_b_next = end_b ? '0 : cur_b + tass_pkg::COORD_W'(1);
      if (end_b) begin
        coord_c_next = end_c ? '0 : cur_c + tass_pkg::COORD_W'(1);
        if (end_c) begin
          coord_d_next = end_d ? '0 : cur_d + tass_pkg::COORD_W'(1);
        end
      end
    end
    if (three_d) begin
      coord_d_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_a <= '0;
      coord_b <= '0;
      coord_c <= '0;
      coord_d <= '0;
    end else if (accept) begin
      coord_a <= coord_a_next;
      coord_b <= coord_b_next;
      coord_c <= coord_c_next;
      coord_d <= coord_d_next;
    end
  end

  // Address is x0 + s1*x1 + pair*x2 + n1*n2*n3*d, operands picked per mode:
  //   swap12: b + n2*a + (n1*n2)*c
  //   swap13: c + n3*b + (n2*n3)*a + vol*d
  //   swap23: a + n1*c + (n1*n3)*b + vol*d
  tass_pkg::coord_t x0, x1, x2;
  tass_pkg::dim_t   s1, pa, pb;

  always_comb begin
    case (mode)
      tass_pkg::MODE_SWAP12: begin
        x0 = cur_b; x1 = cur_a; x2 = cur_c;
        s1 = n2;    pa = n1;    pb = n2;
      end
      tass_pkg::MODE_SWAP13: begin
        x0 = cur_c; x1 = cur_b; x2 = cur_a;
        s1 = n3;    pa = n2;    pb = n3;
      end
      default: begin
        x0 = cur_a; x1 = cur_c; x2 = cur_b;
        s1 = n1;    pa = n1;    pb = n3;
      end
    endcase
  end

  // Stage 1 registers
  tass_pkg::coord_t                 st1_x0, st1_x2;
  logic [tass_pkg::M1_W-1:0]        st1_m1, st1_dn3;
  logic [tass_pkg::PAIR_W-1:0]      st1_pair, st1_p12;
  logic [tass_pkg::ELEM_W-1:0]      st1_element;
  logic                             st1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1_x0      <= x0;
      st1_x2      <= x2;
      st1_m1      <= tass_pkg::M1_W'(s1) * tass_pkg::M1_W'(x1);
      st1_pair    <= tass_pkg::PAIR_W'(pa) * tass_pkg::PAIR_W'(pb);
      st1_p12     <= tass_pkg::PAIR_W'(n1) * tass_pkg::PAIR_W'(n2);
      st1_dn3     <= tass_pkg::M1_W'(n3) * tass_pkg::M1_W'(cur_d);
      st1_element <= s_tdata[tass_pkg::ELEM_W-1:0];
      st1_last    <= fin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: second-level products and the short partial sum.
  // ---------------------------------------------------------------------------
  logic [tass_pkg::M1_W:0]      st2_sum01;
  logic [tass_pkg::M2_W-1:0]    st2_m2;
  logic [tass_pkg::MD_W-1:0]    st2_md;
  logic [tass_pkg::ELEM_W-1:0]  st2_element;
  logic                         st2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && v1) begin
      st2_sum01   <= (tass_pkg::M1_W + 1)'(st1_x0) + (tass_pkg::M1_W + 1)'(st1_m1);
      st2_m2      <= tass_pkg::M2_W'(st1_pair) * tass_pkg::M2_W'(st1_x2);
      st2_md      <= tass_pkg::MD_W'(st1_p12) * tass_pkg::MD_W'(st1_dn3);
      st2_element <= st1_element;
      st2_last    <= st1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: final sum and range check into the output register.
  // ---------------------------------------------------------------------------
  logic [tass_pkg::SUM_W-1:0]     addr_sum;
  logic                           addr_over;
  logic [tass_pkg::ADDR_BITS-1:0] out_addr;
  logic [tass_pkg::ELEM_W-1:0]    out_element;

  assign addr_sum  = tass_pkg::SUM_W'(st2_sum01) + tass_pkg::SUM_W'(st2_m2)
                   + tass_pkg::SUM_W'(st2_md);
  assign addr_over = |addr_sum[tass_pkg::SUM_W-1:tass_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v2) begin
      out_addr    <= addr_over ? '0 : addr_sum[tass_pkg::ADDR_BITS-1:0];
      m_tuser     <= addr_over;
      m_tlast     <= st2_last;
      out_element <= st2_element;
    end
  end

  assign m_tdata = tass_pkg::OUT_DATA_W'({out_element, out_addr});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // input side only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && m_tvalid))
    else $error("input stalled with an empty pipeline stage");

  // the final element of a tensor wraps the counter to the origin
  a_wrap_origin: assert property (@(posedge clk) disable iff (rst)
    (accept && fin) |=> (coord_a == '0 && coord_b == '0 && coord_c == '0 && coord_d == '0))
    else $error("counter did not wrap after the last element");

  // the outer coordinate stays cleared in 3-D mode
  a_outer_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && three_d) |=> (coord_d == '0))
    else $error("outer coordinate advanced in 3-D mode");

  // an out-of-range result carries address zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[tass_pkg::ADDR_BITS-1:0] == '0))
    else $error("range error with nonzero address");

endmodule

// ----- tb/tb_tensor_axis_swap_scatter_unit.sv -----
module tb_tensor_axis_swap_scatter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tass_pkg::*;

  // Mode code three has no name in the package; the block treats it as swap 2,3
  localparam logic [MODE_W-1:0] MODE_ALIAS23 = 2'd3;

  localparam int RUN_ITEMS   = 900;     // random elements after the directed table
  localparam int CYCLE_CAP   = 400000;  // watchdog, far above the slowest legal run
  localparam int PIPE_PAD    = 8;       // pipe is 3 deep, plus spare on top
  localparam int MAX_REPORTS = 10;

  // One destination transaction as seen on the master side
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [ELEM_W-1:0]    elem;
    logic                 last;
    logic                 rerr;
  } dest_item_t;

  // Directed stimulus row: a register write or an element, optionally with a
  // hand-written expected transaction
  typedef struct {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [ELEM_W-1:0]    elem;
    logic                 first;
    logic                 typed;
    dest_item_t           known;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [63:0] element
  logic                  s_tuser;   // [0] first
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [23:0] dest_address, [87:24] element_out
  logic                  m_tlast;
  logic                  m_tuser;   // [0] range_error

  // Shadow copy of the block's registers and source coordinate counter
  logic [MODE_W-1:0] sh_mode;
  dim_t              sh_one, sh_two, sh_three, sh_four;
  coord_t            at_a, at_b, at_c, at_d;

  dest_item_t dest_due[$];   // predicted transactions, oldest first
  plan_row_t  plan[$];

  int         elems_taken = 0;
  int         regs_taken  = 0;
  int         fault_count = 0;
  int         cycle_count = 0;
  int         send_idle   = 0;   // percent of cycles the sender holds off
  int         recv_stall  = 0;   // percent of cycles the receiver stalls
  logic       item_typed  = 1'b0;
  dest_item_t item_known  = '0;

  tensor_axis_swap_scatter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the address generator
  // ---------------------------------------------------------------------------

  // Size zero counts as one, anything past MAX_DIM is clamped
  function automatic longint unsigned clamp_size(input dim_t v);
    longint unsigned r;
    r = v;
    if (r == 0) begin
      r = 1;
    end else if (r > MAX_DIM) begin
      r = MAX_DIM;
    end
    return r;
  endfunction

  // Coordinate sits on (or past) the end of its axis
  function automatic logic wraps(input coord_t c, input longint unsigned n);
    longint unsigned w;
    w = c;
    return (w + 1) >= n;
  endfunction

  function automatic void clear_shadow();
    sh_mode  = MODE_SWAP12;
    sh_one   = dim_t'(1);
    sh_two   = dim_t'(1);
    sh_three = dim_t'(1);
    sh_four  = dim_t'(1);
    at_a = '0;
    at_b = '0;
    at_c = '0;
    at_d = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      REG_MODE:      sh_mode  = val[MODE_W-1:0];
      REG_DIM_ONE:   sh_one   = val;
      REG_DIM_TWO:   sh_two   = val;
      REG_DIM_THREE: sh_three = val;
      REG_DIM_FOUR:  sh_four  = val;
      default: ;     // unused indexes are ignored
    endcase
  endfunction

  // Destination transaction for one source element, then advance the counter
  function automatic dest_item_t scatter_next(input logic [ELEM_W-1:0] elem,
                                              input logic first);
    longint unsigned n1, n2, n3, n4, a, b, c, d, vol, addr;
    logic            three_d, carry;
    dest_item_t      r;
    n1 = clamp_size(sh_one);
    n2 = clamp_size(sh_two);
    n3 = clamp_size(sh_three);
    n4 = clamp_size(sh_four);
    if (first) begin
      at_a = '0;
      at_b = '0;
      at_c = '0;
      at_d = '0;
    end
    three_d = (sh_mode == MODE_SWAP12);
    a = at_a;
    b = at_b;
    c = at_c;
    d = three_d ? 0 : at_d;
    vol = n1 * n2 * n3;
    if (three_d) begin
      addr = b + n2 * a + n1 * n2 * c;
    end else if (sh_mode == MODE_SWAP13) begin
      addr = c + n3 * b + n3 * n2 * a + vol * d;
    end else begin
      // swap 2,3 and the alias code three
      addr = a + n1 * c + n1 * n3 * b + vol * d;
    end
    r.last = wraps(at_a, n1) && wraps(at_b, n2) && wraps(at_c, n3) &&
             (three_d || wraps(at_d, n4));
    if ((addr >> ADDR_BITS) != 0) begin
      r.addr = '0;
      r.rerr = 1'b1;
    end else begin
      r.addr = addr[ADDR_BITS-1:0];
      r.rerr = 1'b0;
    end
    r.elem = elem;
    // mixed-radix advance, axis one fastest; coordinates past a size wrap
    carry = wraps(at_a, n1);
    at_a = carry ? '0 : at_a + 1'b1;
    if (carry) begin
      carry = wraps(at_b, n2);
      at_b = carry ? '0 : at_b + 1'b1;
    end
    if (carry) begin
      carry = wraps(at_c, n3);
      at_c = carry ? '0 : at_c + 1'b1;
    end
    if (carry && !three_d) begin
      carry = wraps(at_d, n4);
      at_d = carry ? '0 : at_d + 1'b1;
    end
    if (three_d) begin
      at_d = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: everything sampled at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_fault(input string what, input dest_item_t want, input dest_item_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t %s: want addr %h elem %h last %b rerr %b, got addr %h elem %h last %b rerr %b",
               $realtime, what, want.addr, want.elem, want.last, want.rerr,
               got.addr, got.elem, got.last, got.rerr);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    dest_item_t want, got;
    if (!rst) begin
      // result side first, so a result can never match an item taken this edge
      if (m_tvalid && m_tready) begin
        got.addr = m_tdata[ADDR_BITS-1:0];
        got.elem = m_tdata[ADDR_BITS +: ELEM_W];
        got.last = m_tlast;
        got.rerr = m_tuser;
        if (dest_due.size() == 0) begin
          report_fault("result with nothing pending", '0, got);
        end else begin
          want = dest_due.pop_front();
          if (got.addr !== want.addr || got.elem !== want.elem ||
              got.last !== want.last || got.rerr !== want.rerr) begin
            report_fault("result mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        regs_taken++;
      end
      if (s_tvalid && s_tready) begin
        // shadow always advances; hand-typed rows override its answer
        want = scatter_next(s_tdata[ELEM_W-1:0], s_tuser);
        if (item_typed) begin
          want = item_known;
        end
        dest_due.push_back(want);
        elems_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb_tensor_axis_swap_scatter_unit: done, errors");
      $finish;
    end
  end

  // Receiver backpressure, changes on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // Leaves s_tvalid high on return; settle() or an idle spell in the next call lowers it
  task automatic push_elem(input logic [ELEM_W-1:0] elem, input logic first,
                           input logic typed, input dest_item_t known);
    int goal;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= elem;
    s_tuser    <= first;
    item_typed = typed;
    item_known = known;
    goal = elems_taken + 1;
    do @(negedge clk); while (elems_taken < goal);
  endtask

  // Leaves cfg_valid high on return; the caller lowers it after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int goal;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    goal = regs_taken + 1;
    do @(negedge clk); while (regs_taken < goal);
  endtask

  // Sender holds off until every pending transaction is out and the pipe is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (dest_due.size() != 0) @(negedge clk);
    repeat (PIPE_PAD) @(negedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] rnd_elem();
    logic [ELEM_W-1:0] e;
    case ($urandom_range(0, 15))
      0:       e = '0;
      1:       e = '1;
      default: e = {$urandom, $urandom};
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic plan_row_t elem_row(input logic [ELEM_W-1:0] e, input logic f);
    plan_row_t r;
    r = '{default: '0};
    r.elem  = e;
    r.first = f;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [ELEM_W-1:0] e, input logic f,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic last, input logic rerr);
    plan_row_t r;
    r = elem_row(e, f);
    r.typed      = 1'b1;
    r.known.addr = addr;
    r.known.elem = e;
    r.known.last = last;
    r.known.rerr = rerr;
    return r;
  endfunction

  task automatic build_plan();
    // after reset: swap 1,2 with every size one, each element is a whole tensor
    plan.push_back(known_row(64'h0, 1'b1, 24'd0, 1'b1, 1'b0));
    plan.push_back(known_row('1, 1'b0, 24'd0, 1'b1, 1'b0));
    // swap 1,3 with only the outer axis: the address is the outer coordinate
    plan.push_back(reg_row(REG_MODE, CFG_W'(MODE_SWAP13)));
    plan.push_back(reg_row(REG_DIM_FOUR, CFG_W'(MAX_DIM)));
    plan.push_back(known_row(64'h5555_5555_5555_5555, 1'b1, 24'd0, 1'b0, 1'b0));
    plan.push_back(known_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 24'd1, 1'b0, 1'b0));
    plan.push_back(known_row(64'h0123_4567_89AB_CDEF, 1'b0, 24'd2, 1'b0, 1'b0));
    // grow inner sizes mid-tensor (2047 clamps): volume 2^30 times outer 3 overflows
    plan.push_back(reg_row(REG_DIM_ONE, CFG_W'(MAX_DIM)));
    plan.push_back(reg_row(REG_DIM_TWO, '1));
    plan.push_back(reg_row(REG_DIM_THREE, CFG_W'(MAX_DIM)));
    plan.push_back(known_row(64'hFEDC_BA98_7654_3210, 1'b0, 24'd0, 1'b0, 1'b1));
    // alias mode, zero sizes, outer size 2 while the outer coordinate is 3:
    // coordinates past their size still count in the address and as at the end
    plan.push_back(reg_row(REG_MODE, CFG_W'(MODE_ALIAS23)));
    plan.push_back(reg_row(REG_DIM_ONE, '0));
    plan.push_back(reg_row(REG_DIM_TWO, '0));
    plan.push_back(reg_row(REG_DIM_THREE, '0));
    plan.push_back(reg_row(REG_DIM_FOUR, CFG_W'(2)));
    plan.push_back(known_row(rnd_elem(), 1'b0, 24'd4, 1'b1, 1'b0));
    plan.push_back(known_row(rnd_elem(), 1'b0, 24'd0, 1'b0, 1'b0));
    plan.push_back(known_row(rnd_elem(), 1'b0, 24'd1, 1'b1, 1'b0));
    // 3-D swap with a stray outer size, restarted mid-tensor
    plan.push_back(reg_row(REG_MODE, CFG_W'(MODE_SWAP12)));
    plan.push_back(reg_row(REG_DIM_ONE, CFG_W'(3)));
    plan.push_back(reg_row(REG_DIM_TWO, CFG_W'(2)));
    plan.push_back(reg_row(REG_DIM_THREE, CFG_W'(1)));
    plan.push_back(reg_row(REG_DIM_FOUR, CFG_W'(5)));
    for (int i = 0; i < 6; i++) begin
      plan.push_back(elem_row(rnd_elem(), i == 0 || i == 4));
    end
    // 4-D swap 2,3, one full tensor
    plan.push_back(reg_row(REG_MODE, CFG_W'(MODE_SWAP23)));
    plan.push_back(reg_row(REG_DIM_ONE, CFG_W'(2)));
    plan.push_back(reg_row(REG_DIM_TWO, CFG_W'(2)));
    plan.push_back(reg_row(REG_DIM_THREE, CFG_W'(1)));
    plan.push_back(reg_row(REG_DIM_FOUR, CFG_W'(2)));
    for (int i = 0; i < 8; i++) begin
      plan.push_back(elem_row(rnd_elem(), i == 0));
    end
  endtask

  task automatic walk_plan();
    logic cfg_open;
    cfg_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        push_elem(plan[i].elem, plan[i].first, plan[i].typed, plan[i].known);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random phases
  // ---------------------------------------------------------------------------

  // shapes 7 and 9: large sizes, any mode; shape 8: swap 1,3 with large sizes, which
  // runs past the address range within a few dozen elements; else small sizes
  task automatic random_setup(input int shape);
    logic [CFG_W-1:0] v;
    dim_t             sz;
    logic             big;
    big = (shape >= 7);
    v = CFG_W'($urandom);
    v[MODE_W-1:0] = (shape == 8) ? MODE_SWAP13 : MODE_W'($urandom_range(0, 3));
    if (big || $urandom_range(0, 3) != 0) begin
      write_reg(REG_MODE, v);
    end
    for (int k = int'(REG_DIM_ONE); k <= int'(REG_DIM_FOUR); k++) begin
      if (big) begin
        sz = dim_t'($urandom_range(900, 2047));
      end else begin
        case ($urandom_range(0, 19))
          0:       sz = '0;
          1:       sz = dim_t'($urandom_range(MAX_DIM + 1, 2047));
          default: sz = dim_t'($urandom_range(1, 4));
        endcase
      end
      if (big || $urandom_range(0, 3) != 0) begin
        write_reg(CFG_IDX_W'(k), sz);
      end
    end
    // writes to unused indexes must change nothing
    if ($urandom_range(0, 6) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_DIM_FOUR) + 1, (1 << CFG_IDX_W) - 1)),
                CFG_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phases();
    int   phase, sent, count, shape;
    logic fresh;
    phase = 0;
    sent  = 0;
    while (sent < RUN_ITEMS) begin
      settle();
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 51; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      shape = $urandom_range(0, 9);
      random_setup(shape);
      // most phases start a fresh tensor; the rest carry the counter over
      fresh = (shape >= 7) || ($urandom_range(0, 3) != 0);
      count = (shape >= 7) ? $urandom_range(40, 100) : $urandom_range(8, 48);
      for (int i = 0; i < count; i++) begin
        push_elem(rnd_elem(), (i == 0) ? fresh : ($urandom_range(0, 99) < 3), 1'b0, '0);
        sent++;
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    clear_shadow();
    build_plan();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    walk_plan();
    random_phases();

    // drain: nothing pending, then let the pipe run dry
    settle();
    if (fault_count == 0 && dest_due.size() == 0) begin
      $display("tb_tensor_axis_swap_scatter_unit: done, clean");
    end else begin
      $display("tb_tensor_axis_swap_scatter_unit: done, errors");
    end
    $finish;
  end

endmodule
